### hw/rtl/rkt_pkg.sv
package rkt_pkg;

   localparam int CMD_W     = 2;
   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 64;
   localparam int SIZE_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int LIVE_W    = 9;
   localparam int REF_W     = 24;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_ADD     = 2'd0;
   localparam cmd_type CMD_ACQUIRE = 2'd1;
   localparam cmd_type CMD_RELEASE = 2'd2;
   localparam cmd_type CMD_UPDATE  = 2'd3;

   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_NOT_FOUND     = 3'd1;
   localparam status_type ST_SIZE_MISMATCH = 3'd2;
   localparam status_type ST_PRESENT       = 3'd3;
   localparam status_type ST_TOO_LARGE     = 3'd4;
   localparam status_type ST_FULL          = 3'd5;
   localparam status_type ST_SATURATED     = 3'd6;

endpackage

### hw/rtl/refcounted_key_table_core.sv
// Reference-counted key table: add, acquire, release and update commands on up to ENTRIES
// densely packed entries, one response word per request word. Every command first scans
// the live entries for its key, one entry per cycle through the single read port of the
// entry memory; a hit ends the scan early. A release that drops the count to zero then
// moves the last entry into the freed slot through the S_LAST and S_MOVE states. One
// command is worked on at a time and the next request word is taken in S_IDLE, which is
// entered as the response is registered; a finished response waits in the output register
// while that next word is worked on, and a command that finishes before it has left holds
// until rsp_ready. No clearing pass follows reset.
module refcounted_key_table_core #(
   parameter int ENTRIES       = 256,
   parameter int PAYLOAD_BYTES = 8,
   parameter int KEY_BITS      = 64,
   parameter int COUNT_BITS    = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rkt_pkg::CMD_W-1:0]       req_command,
   input  logic [rkt_pkg::KEY_W-1:0]       req_key,
   input  logic [rkt_pkg::PAYLOAD_W-1:0]   req_payload,
   input  logic [rkt_pkg::SIZE_W-1:0]      req_payload_size,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rkt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rkt_pkg::PAYLOAD_W-1:0]   rsp_value,
   output logic                            rsp_destroyed,
   output logic [rkt_pkg::LIVE_W-1:0]      rsp_live_count,
   output logic [rkt_pkg::REF_W-1:0]       rsp_ref_total
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int OCC_W  = (CNT_W > rkt_pkg::LIVE_W) ? CNT_W : rkt_pkg::LIVE_W;
   localparam int SUM_W  = (COUNT_BITS + CNT_W > rkt_pkg::REF_W) ?
                           (COUNT_BITS + CNT_W) : rkt_pkg::REF_W;
   localparam int PAY_W  = PAYLOAD_BYTES * 8;
   localparam int KEY_LO = 0;
   localparam int PAY_LO = KEY_LO + KEY_BITS;
   localparam int SZ_LO  = PAY_LO + PAY_W;
   localparam int CT_LO  = SZ_LO + rkt_pkg::SIZE_W;
   localparam int ENT_W  = CT_LO + COUNT_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_LAST = 3'd3;
   localparam logic [2:0] S_MOVE = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;
   logic [SUM_W-1:0]            sum_ff, sum_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        hit_ff, hit_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]            rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic [ENT_W-1:0]            hit_entry_ff, hit_entry_in;
   rkt_pkg::cmd_type            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]         key_ff, key_in;
   logic [PAY_W-1:0]            pay_ff, pay_in;
   logic [rkt_pkg::SIZE_W-1:0]  size_ff, size_in;
   rkt_pkg::status_type         res_status_ff, res_status_in;
   logic [PAY_W-1:0]            res_pay_ff, res_pay_in;
   logic                        res_destroyed_ff, res_destroyed_in;
   rkt_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [PAY_W-1:0]            rsp_pay_ff, rsp_pay_in;
   logic                        rsp_destroyed_ff, rsp_destroyed_in;
   logic [rkt_pkg::LIVE_W-1:0]  rsp_live_ff, rsp_live_in;
   logic [rkt_pkg::REF_W-1:0]   rsp_ref_ff, rsp_ref_in;

   logic                        mem_we, mem_re;
   logic [IDX_W-1:0]            mem_wa, mem_ra;
   logic [ENT_W-1:0]            mem_wd, mem_rd;

   logic [PAY_W-1:0]            masked_pay;
   logic [COUNT_BITS-1:0]       hit_cnt, dec_cnt;
   logic [rkt_pkg::SIZE_W-1:0]  hit_size;
   logic [OCC_W-1:0]            occ_m1;
   logic                        key_match;

   rkt_store #(
      .DEPTH (ENTRIES),
      .WIDTH (ENT_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_en   (mem_re),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   always_comb begin
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         masked_pay[b*8 +: 8] = (rkt_pkg::SIZE_W'(b) < size_ff) ? pay_ff[b*8 +: 8] : 8'h00;
      end
   end

   assign hit_cnt   = hit_entry_ff[CT_LO +: COUNT_BITS];
   assign hit_size  = hit_entry_ff[SZ_LO +: rkt_pkg::SIZE_W];
   assign dec_cnt   = (hit_cnt != '0) ? (hit_cnt - COUNT_BITS'(1)) : '0;
   assign occ_m1    = occ_ff - OCC_W'(1);
   assign key_match = rd_pend_ff && (mem_rd[KEY_LO +: KEY_BITS] == key_ff);

   always_comb begin
      state_in         = state_ff;
      occ_in           = occ_ff;
      sum_in           = sum_ff;
      scan_in          = scan_ff;
      rd_pend_in       = 1'b0;
      hit_in           = hit_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rd_idx_in        = rd_idx_ff;
      hit_idx_in       = hit_idx_ff;
      hit_entry_in     = hit_entry_ff;
      cmd_in           = cmd_ff;
      key_in           = key_ff;
      pay_in           = pay_ff;
      size_in          = size_ff;
      res_status_in    = res_status_ff;
      res_pay_in       = res_pay_ff;
      res_destroyed_in = res_destroyed_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_pay_in       = rsp_pay_ff;
      rsp_destroyed_in = rsp_destroyed_ff;
      rsp_live_in      = rsp_live_ff;
      rsp_ref_in       = rsp_ref_ff;
      mem_we           = 1'b0;
      mem_wa           = hit_idx_ff;
      mem_wd           = hit_entry_ff;
      mem_re           = 1'b0;
      mem_ra           = scan_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = req_key[KEY_BITS-1:0];
               pay_in   = req_payload[PAY_W-1:0];
               size_in  = req_payload_size;
               scan_in  = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (key_match) begin
               hit_in       = 1'b1;
               hit_idx_in   = rd_idx_ff;
               hit_entry_in = mem_rd;
               state_in     = S_EXEC;
            end else if (OCC_W'(scan_ff) >= occ_ff) begin
               state_in = S_EXEC;
            end else begin
               mem_re     = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = scan_ff[IDX_W-1:0];
               scan_in    = scan_ff + CNT_W'(1);
            end
         end
         S_EXEC: begin
            res_status_in    = rkt_pkg::ST_OK;
            res_pay_in       = '0;
            res_destroyed_in = 1'b0;
            state_in         = S_DONE;
            unique case (cmd_ff)
               rkt_pkg::CMD_ADD: begin
                  if (size_ff > rkt_pkg::SIZE_W'(PAYLOAD_BYTES)) begin
                     res_status_in = rkt_pkg::ST_TOO_LARGE;
                  end else if (hit_ff) begin
                     res_status_in = rkt_pkg::ST_PRESENT;
                  end else if (occ_ff >= OCC_W'(ENTRIES)) begin
                     res_status_in = rkt_pkg::ST_FULL;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = occ_ff[IDX_W-1:0];
                     mem_wd = {COUNT_BITS'(1), size_ff, masked_pay, key_ff};
                     occ_in = occ_ff + OCC_W'(1);
                     sum_in = sum_ff + SUM_W'(1);
                  end
               end
               rkt_pkg::CMD_ACQUIRE: begin
                  if (!hit_ff) begin
                     res_status_in = rkt_pkg::ST_NOT_FOUND;
                  end else if (size_ff != hit_size) begin
                     res_status_in = rkt_pkg::ST_SIZE_MISMATCH;
                  end else if (&hit_cnt) begin
                     res_status_in = rkt_pkg::ST_SATURATED;
                  end else begin
                     mem_we = 1'b1;
                     mem_wd = hit_entry_ff;
                     mem_wd[CT_LO +: COUNT_BITS] = hit_cnt + COUNT_BITS'(1);
                     sum_in     = sum_ff + SUM_W'(1);
                     res_pay_in = hit_entry_ff[PAY_LO +: PAY_W];
                  end
               end
               rkt_pkg::CMD_RELEASE: begin
                  if (!hit_ff) begin
                     res_status_in = rkt_pkg::ST_NOT_FOUND;
                  end else begin
                     if ((hit_cnt != '0) && (sum_ff != '0)) begin
                        sum_in = sum_ff - SUM_W'(1);
                     end
                     if (dec_cnt == '0) begin
                        res_destroyed_in = 1'b1;
                        state_in         = S_LAST;
                     end else begin
                        mem_we = 1'b1;
                        mem_wd = hit_entry_ff;
                        mem_wd[CT_LO +: COUNT_BITS] = dec_cnt;
                     end
                  end
               end
               rkt_pkg::CMD_UPDATE: begin
                  if (!hit_ff) begin
                     res_status_in = rkt_pkg::ST_NOT_FOUND;
                  end else if (size_ff != hit_size) begin
                     res_status_in = rkt_pkg::ST_SIZE_MISMATCH;
                  end else begin
                     mem_we = 1'b1;
                     mem_wd = hit_entry_ff;
                     mem_wd[PAY_LO +: PAY_W] = masked_pay;
                  end
               end
               default: begin
                  res_status_in = rkt_pkg::ST_NOT_FOUND;
               end
            endcase
         end
         S_LAST: begin
            mem_re   = 1'b1;
            mem_ra   = occ_m1[IDX_W-1:0];
            state_in = S_MOVE;
         end
         S_MOVE: begin
            mem_we   = 1'b1;
            mem_wa   = hit_idx_ff;
            mem_wd   = mem_rd;
            occ_in   = occ_m1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_status_in    = res_status_ff;
               rsp_pay_in       = res_pay_ff;
               rsp_destroyed_in = res_destroyed_ff;
               rsp_live_in      = occ_ff[rkt_pkg::LIVE_W-1:0];
               rsp_ref_in       = sum_ff[rkt_pkg::REF_W-1:0];
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         sum_ff       <= '0;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         sum_ff       <= sum_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff        <= rd_idx_in;
      hit_idx_ff       <= hit_idx_in;
      hit_entry_ff     <= hit_entry_in;
      cmd_ff           <= cmd_in;
      key_ff           <= key_in;
      pay_ff           <= pay_in;
      size_ff          <= size_in;
      res_status_ff    <= res_status_in;
      res_pay_ff       <= res_pay_in;
      res_destroyed_ff <= res_destroyed_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_pay_ff       <= rsp_pay_in;
      rsp_destroyed_ff <= rsp_destroyed_in;
      rsp_live_ff      <= rsp_live_in;
      rsp_ref_ff       <= rsp_ref_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value      = rkt_pkg::PAYLOAD_W'(rsp_pay_ff);
   assign rsp_destroyed  = rsp_destroyed_ff;
   assign rsp_live_count = rsp_live_ff;
   assign rsp_ref_total  = rsp_ref_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(ENTRIES))
      else $error("live entry count beyond capacity");

   a_hit_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && hit_ff) |-> (OCC_W'(hit_idx_ff) < occ_ff))
      else $error("hit index outside live entries");

   a_destroy_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_destroyed_ff |-> rsp_status_ff == rkt_pkg::ST_OK)
      else $error("destroyed flagged on failed word");

   a_move_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |=> (occ_ff == $past(occ_ff) - OCC_W'(1)))
      else $error("removal did not shrink table");

endmodule

### hw/rtl/rkt_store.sv
module rkt_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 148
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sim/refcounted_key_table_core_test.sv
`timescale 1ns / 1ps

module refcounted_key_table_core_test;

   localparam int TABLE_DEPTH    = 256;
   localparam int MAX_BYTES      = 8;
   localparam int REF_BITS       = 16;
   localparam int RANDOM_WORDS   = 290;
   localparam int HOLD_OFF       = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 300;

   localparam logic [REF_BITS-1:0]          REF_MAX  = '1;
   localparam logic [rkt_pkg::KEY_W-1:0]    ALL_ONES = 64'hffff_ffff_ffff_ffff;
   localparam logic [rkt_pkg::KEY_W-1:0]    ALT_A    = 64'h5555_5555_5555_5555;
   localparam logic [rkt_pkg::KEY_W-1:0]    ALT_B    = 64'haaaa_aaaa_aaaa_aaaa;
   localparam logic [rkt_pkg::KEY_W-1:0]    TOP_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [rkt_pkg::KEY_W-1:0]    PATTERN  = 64'h0123_4567_89ab_cdef;
   localparam logic [rkt_pkg::KEY_W-1:0]    HOT_KEY  = 64'h0000_0000_0000_0001;

   typedef struct packed {
      rkt_pkg::status_type             status;
      logic [rkt_pkg::PAYLOAD_W-1:0]   payload;
      logic                            destroyed;
      logic [rkt_pkg::LIVE_W-1:0]      live;
      logic [rkt_pkg::REF_W-1:0]       refs;
   } outcome_type;

   typedef struct packed {
      rkt_pkg::cmd_type                cmd;
      logic [rkt_pkg::KEY_W-1:0]       key;
      logic [rkt_pkg::PAYLOAD_W-1:0]   payload;
      logic [rkt_pkg::SIZE_W-1:0]      size;
      logic                            fixed;
      outcome_type                     want;
   } row_type;

   localparam outcome_type NO_WANT = '0;

   // rows with fixed set carry their expected response word
   localparam row_type DIRECTED_ROWS [0:24] = '{
      '{rkt_pkg::CMD_ACQUIRE, 64'h0, ALT_B, 4'd0, 1'b1,
        '{rkt_pkg::ST_NOT_FOUND, 64'h0, 1'b0, 9'd0, 24'd0}},
      '{rkt_pkg::CMD_RELEASE, ALL_ONES, 64'h0, 4'd8, 1'b1,
        '{rkt_pkg::ST_NOT_FOUND, 64'h0, 1'b0, 9'd0, 24'd0}},
      '{rkt_pkg::CMD_UPDATE, 64'h0, ALL_ONES, 4'd8, 1'b1,
        '{rkt_pkg::ST_NOT_FOUND, 64'h0, 1'b0, 9'd0, 24'd0}},
      '{rkt_pkg::CMD_ADD, 64'h0, ALL_ONES, 4'd9, 1'b1,
        '{rkt_pkg::ST_TOO_LARGE, 64'h0, 1'b0, 9'd0, 24'd0}},
      '{rkt_pkg::CMD_ADD, 64'h0, ALL_ONES, 4'd15, 1'b1,
        '{rkt_pkg::ST_TOO_LARGE, 64'h0, 1'b0, 9'd0, 24'd0}},
      '{rkt_pkg::CMD_ADD, 64'h0, ALL_ONES, 4'd0, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd1, 24'd1}},
      '{rkt_pkg::CMD_ADD, ALL_ONES, ALL_ONES, 4'd8, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd2, 24'd2}},
      '{rkt_pkg::CMD_ADD, 64'h0, ALT_A, 4'd3, 1'b1,
        '{rkt_pkg::ST_PRESENT, 64'h0, 1'b0, 9'd2, 24'd2}},
      '{rkt_pkg::CMD_ADD, 64'h0, ALT_A, 4'd12, 1'b1,
        '{rkt_pkg::ST_TOO_LARGE, 64'h0, 1'b0, 9'd2, 24'd2}},
      '{rkt_pkg::CMD_ACQUIRE, ALL_ONES, 64'h0, 4'd8, 1'b1,
        '{rkt_pkg::ST_OK, ALL_ONES, 1'b0, 9'd2, 24'd3}},
      '{rkt_pkg::CMD_ACQUIRE, 64'h0, ALL_ONES, 4'd0, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd2, 24'd4}},
      '{rkt_pkg::CMD_ACQUIRE, ALL_ONES, 64'h0, 4'd7, 1'b1,
        '{rkt_pkg::ST_SIZE_MISMATCH, 64'h0, 1'b0, 9'd2, 24'd4}},
      '{rkt_pkg::CMD_UPDATE, ALL_ONES, PATTERN, 4'd8, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd2, 24'd4}},
      '{rkt_pkg::CMD_UPDATE, 64'h0, ALL_ONES, 4'd1, 1'b1,
        '{rkt_pkg::ST_SIZE_MISMATCH, 64'h0, 1'b0, 9'd2, 24'd4}},
      '{rkt_pkg::CMD_ACQUIRE, ALL_ONES, 64'h0, 4'd8, 1'b1,
        '{rkt_pkg::ST_OK, PATTERN, 1'b0, 9'd2, 24'd5}},
      '{rkt_pkg::CMD_ADD, ALT_A, ALT_B, 4'd3, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd3, 24'd6}},
      '{rkt_pkg::CMD_ACQUIRE, ALT_A, 64'h0, 4'd3, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0000_0000_00aa_aaaa, 1'b0, 9'd3, 24'd7}},
      '{rkt_pkg::CMD_RELEASE, 64'h0, ALL_ONES, 4'd15, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b0, 9'd3, 24'd6}},
      '{rkt_pkg::CMD_RELEASE, 64'h0, 64'h0, 4'd0, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0, 1'b1, 9'd2, 24'd5}},
      '{rkt_pkg::CMD_ACQUIRE, ALT_A, 64'h0, 4'd3, 1'b1,
        '{rkt_pkg::ST_OK, 64'h0000_0000_00aa_aaaa, 1'b0, 9'd2, 24'd6}},
      '{rkt_pkg::CMD_ADD, TOP_BIT, ALT_A, 4'd5, 1'b0, NO_WANT},
      '{rkt_pkg::CMD_UPDATE, TOP_BIT, ALT_B, 4'd5, 1'b0, NO_WANT},
      '{rkt_pkg::CMD_ACQUIRE, TOP_BIT, 64'h0, 4'd5, 1'b0, NO_WANT},
      '{rkt_pkg::CMD_RELEASE, ALL_ONES, 64'h0, 4'd0, 1'b0, NO_WANT},
      '{rkt_pkg::CMD_ACQUIRE, ~TOP_BIT, 64'h0, 4'd5, 1'b0, NO_WANT}
   };

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_ready;
   logic [rkt_pkg::CMD_W-1:0]       req_command      = '0;
   logic [rkt_pkg::KEY_W-1:0]       req_key          = '0;
   logic [rkt_pkg::PAYLOAD_W-1:0]   req_payload      = '0;
   logic [rkt_pkg::SIZE_W-1:0]      req_payload_size = '0;
   logic                            rsp_valid;
   logic                            rsp_ready        = 1'b0;
   logic [rkt_pkg::STATUS_W-1:0]    rsp_status;
   logic [rkt_pkg::PAYLOAD_W-1:0]   rsp_value;
   logic                            rsp_destroyed;
   logic [rkt_pkg::LIVE_W-1:0]      rsp_live_count;
   logic [rkt_pkg::REF_W-1:0]       rsp_ref_total;

   // mirror of the table contents
   logic [rkt_pkg::KEY_W-1:0]       slot_key     [TABLE_DEPTH];
   logic [rkt_pkg::PAYLOAD_W-1:0]   slot_payload [TABLE_DEPTH];
   logic [rkt_pkg::SIZE_W-1:0]      slot_bytes   [TABLE_DEPTH];
   logic [REF_BITS-1:0]             slot_refs    [TABLE_DEPTH];
   int unsigned                     slots_used = 0;
   int unsigned                     refs_held  = 0;

   outcome_type            owed_responses [$];
   int                     fail_count    = 0;
   int                     idle_cycles   = 0;
   int                     burst_left    = 0;
   bit                     steady_flow   = 1'b0;
   bit                     random_phase  = 1'b0;
   bit                     hold_off_done = 1'b0;
   int                     hold_left     = 0;
   int                     stall_mode    = 0;
   int                     rx_cycle      = 0;

   refcounted_key_table_core #(
      .ENTRIES       (TABLE_DEPTH),
      .PAYLOAD_BYTES (MAX_BYTES),
      .KEY_BITS      (rkt_pkg::KEY_W),
      .COUNT_BITS    (REF_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_key          (req_key),
      .req_payload      (req_payload),
      .req_payload_size (req_payload_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_value        (rsp_value),
      .rsp_destroyed    (rsp_destroyed),
      .rsp_live_count   (rsp_live_count),
      .rsp_ref_total    (rsp_ref_total)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int find_slot(input logic [rkt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < int'(slots_used); i++) begin
         if (slot_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic outcome_type table_apply(input rkt_pkg::cmd_type cmd,
                                               input logic [rkt_pkg::KEY_W-1:0] key,
                                               input logic [rkt_pkg::PAYLOAD_W-1:0] payload,
                                               input logic [rkt_pkg::SIZE_W-1:0] size);
      outcome_type                     o;
      int                              slot;
      int                              last;
      logic [rkt_pkg::PAYLOAD_W-1:0]   kept;
      o = '0;
      o.status = rkt_pkg::ST_OK;
      slot = find_slot(key);
      if (size == 0) kept = '0;
      else if (size >= MAX_BYTES) kept = payload;
      else kept = payload & ((64'd1 << (8 * size)) - 64'd1);
      case (cmd)
         rkt_pkg::CMD_ADD: begin
            if (size > MAX_BYTES) o.status = rkt_pkg::ST_TOO_LARGE;
            else if (slot >= 0) o.status = rkt_pkg::ST_PRESENT;
            else if (slots_used >= TABLE_DEPTH) o.status = rkt_pkg::ST_FULL;
            else begin
               slot_key[slots_used]     = key;
               slot_payload[slots_used] = kept;
               slot_bytes[slots_used]   = size;
               slot_refs[slots_used]    = REF_BITS'(1);
               slots_used++;
               refs_held++;
            end
         end
         rkt_pkg::CMD_ACQUIRE: begin
            if (slot < 0) o.status = rkt_pkg::ST_NOT_FOUND;
            else if (size != slot_bytes[slot]) o.status = rkt_pkg::ST_SIZE_MISMATCH;
            else if (slot_refs[slot] == REF_MAX) o.status = rkt_pkg::ST_SATURATED;
            else begin
               slot_refs[slot]++;
               refs_held++;
               o.payload = slot_payload[slot];
            end
         end
         rkt_pkg::CMD_RELEASE: begin
            if (slot < 0) o.status = rkt_pkg::ST_NOT_FOUND;
            else begin
               if (slot_refs[slot] > 0) begin
                  slot_refs[slot]--;
                  if (refs_held > 0) refs_held--;
               end
               if (slot_refs[slot] == 0) begin
                  last = int'(slots_used) - 1;
                  slot_key[slot]     = slot_key[last];
                  slot_payload[slot] = slot_payload[last];
                  slot_bytes[slot]   = slot_bytes[last];
                  slot_refs[slot]    = slot_refs[last];
                  slots_used--;
                  o.destroyed = 1'b1;
               end
            end
         end
         default: begin
            if (slot < 0) o.status = rkt_pkg::ST_NOT_FOUND;
            else if (size != slot_bytes[slot]) o.status = rkt_pkg::ST_SIZE_MISMATCH;
            else slot_payload[slot] = kept;
         end
      endcase
      o.live = slots_used[rkt_pkg::LIVE_W-1:0];
      o.refs = refs_held[rkt_pkg::REF_W-1:0];
      return o;
   endfunction

   task automatic send_command(input rkt_pkg::cmd_type cmd,
                               input logic [rkt_pkg::KEY_W-1:0] key,
                               input logic [rkt_pkg::PAYLOAD_W-1:0] payload,
                               input logic [rkt_pkg::SIZE_W-1:0] size,
                               input bit fixed, input outcome_type fixed_want);
      outcome_type predicted;
      int          gap;
      if (!steady_flow && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_key          <= key;
      req_payload      <= payload;
      req_payload_size <= size;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = table_apply(cmd, key, payload, size);
      owed_responses.push_back(fixed ? fixed_want : predicted);
   endtask

   // response checking and receiver stalls
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_responses.size() == 0) begin
            $error("response word with nothing outstanding");
            fail_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_value !== want.payload) begin
               $error("value: expected %h, got %h", want.payload, rsp_value);
               fail_count++;
            end
            if (rsp_destroyed !== want.destroyed) begin
               $error("destroyed: expected %0d, got %0d", want.destroyed, rsp_destroyed);
               fail_count++;
            end
            if (rsp_live_count !== want.live) begin
               $error("live_count: expected %0d, got %0d", want.live, rsp_live_count);
               fail_count++;
            end
            if (rsp_ref_total !== want.refs) begin
               $error("ref_total: expected %0d, got %0d", want.refs, rsp_ref_total);
               fail_count++;
            end
         end
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      if (reset) rsp_ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (random_phase && !hold_off_done) begin
         hold_off_done <= 1'b1;
         hold_left     <= HOLD_OFF;
         rsp_ready     <= 1'b0;
      end else if (steady_flow) rsp_ready <= 1'b1;
      else begin
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ((rx_cycle % 7) < 4);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [rkt_pkg::KEY_W-1:0]     key_pool [16];
      logic [rkt_pkg::KEY_W-1:0]     key;
      logic [rkt_pkg::SIZE_W-1:0]    size;
      rkt_pkg::cmd_type              cmd;
      int                            slot;
      int                            pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].payload,
                      DIRECTED_ROWS[i].size, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      end

      // fill the table, then probe it while full
      while (slots_used < TABLE_DEPTH) begin
         send_command(rkt_pkg::CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom},
                      rkt_pkg::SIZE_W'($urandom_range(0, MAX_BYTES)), 1'b0, NO_WANT);
      end
      send_command(rkt_pkg::CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd4,
                   1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_ADD, ALT_A, {$urandom, $urandom}, 4'd3, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 4'd11,
                   1'b0, NO_WANT);
      key = slot_key[TABLE_DEPTH-1];
      size = slot_bytes[TABLE_DEPTH-1];
      send_command(rkt_pkg::CMD_ACQUIRE, key, '0, size, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_UPDATE, key, {$urandom, $urandom}, size, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_ACQUIRE, key, '0, size, 1'b0, NO_WANT);

      // drain from the front so every removal moves the last entry
      while (slots_used > 0) begin
         send_command(rkt_pkg::CMD_RELEASE, slot_key[0], {$urandom, $urandom},
                      rkt_pkg::SIZE_W'($urandom_range(0, 15)), 1'b0, NO_WANT);
      end

      // one hot key worked back to back
      steady_flow = 1'b1;
      send_command(rkt_pkg::CMD_ADD, HOT_KEY, {$urandom, $urandom}, 4'd2, 1'b0, NO_WANT);
      repeat (8) begin
         send_command(rkt_pkg::CMD_ACQUIRE, HOT_KEY, '0, 4'd2, 1'b0, NO_WANT);
      end
      send_command(rkt_pkg::CMD_ACQUIRE, HOT_KEY, '0, 4'd2, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_RELEASE, HOT_KEY, '0, 4'd2, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_ACQUIRE, HOT_KEY, '0, 4'd2, 1'b0, NO_WANT);
      send_command(rkt_pkg::CMD_ACQUIRE, HOT_KEY, '0, 4'd2, 1'b0, NO_WANT);
      steady_flow = 1'b0;

      key_pool[0] = '0;
      key_pool[1] = ALL_ONES;
      key_pool[2] = TOP_BIT;
      key_pool[3] = HOT_KEY;
      key_pool[4] = ALT_A;
      for (int i = 5; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      random_phase = 1'b1;
      repeat (RANDOM_WORDS) begin
         key = key_pool[$urandom_range(0, 15)];
         if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
         pick = $urandom_range(0, 99);
         if (pick < 30) cmd = rkt_pkg::CMD_ADD;
         else if (pick < 60) cmd = rkt_pkg::CMD_ACQUIRE;
         else if (pick < 82) cmd = rkt_pkg::CMD_RELEASE;
         else cmd = rkt_pkg::CMD_UPDATE;
         slot = find_slot(key);
         if (slot >= 0 && (cmd == rkt_pkg::CMD_ACQUIRE || cmd == rkt_pkg::CMD_UPDATE) &&
             $urandom_range(0, 7) != 0)
            size = slot_bytes[slot];
         else if ($urandom_range(0, 15) == 0)
            size = rkt_pkg::SIZE_W'($urandom_range(MAX_BYTES + 1, 15));
         else size = rkt_pkg::SIZE_W'($urandom_range(0, MAX_BYTES));
         send_command(cmd, key, {$urandom, $urandom}, size, 1'b0, NO_WANT);
      end
      req_valid <= 1'b0;

      while (owed_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
